// ===== hw/rtl/npcs_pkg.sv =====
package npcs_pkg;

  localparam int CHAN_W = 8;
  localparam int IDX_W  = 8;
  localparam int SQ_W   = 2 * CHAN_W;
  localparam int DIST_W = 18;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  localparam int RGB_W = $bits(rgb_t);

  // Control that travels alongside one palette entry through the scan pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

// ===== hw/rtl/nearest_palette_color_search.sv =====
// Write beat: taken while idle and stored if its index lies inside the palette; ready stays high.
// Query beat: the palette RAM is read one entry per cycle, then square and sum stages;
// the result register loads once the last entry's distance has been compared and the
// register is free, and the next beat is taken only after that load.
// A stalled result register holds the block in its last state until it drains.
// Reset: synchronous, active low; clears control and the result valid, palette untouched.
module nearest_palette_color_search #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [npcs_pkg::IDX_W-1:0]      in_entry_index,
  input  logic [npcs_pkg::CHAN_W-1:0]     in_red,
  input  logic [npcs_pkg::CHAN_W-1:0]     in_green,
  input  logic [npcs_pkg::CHAN_W-1:0]     in_blue,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [npcs_pkg::IDX_W-1:0]      out_best_index,
  output logic [npcs_pkg::DIST_W-1:0]     out_best_distance,
  output logic                            out_exact_match
);

  localparam int AW = $clog2(PALETTE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

  state_t                       state_r, state_nxt;
  logic [AW-1:0]                addr_r, addr_nxt;
  npcs_pkg::rgb_t               query_r, query_nxt;
  logic [npcs_pkg::IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [npcs_pkg::DIST_W-1:0]  best_dist_r, best_dist_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [npcs_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [npcs_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;
  npcs_pkg::tag_t               tag_rd_r, tag_rd_nxt;

  logic                         accept;
  logic                         ram_we;
  logic                         ram_re;
  npcs_pkg::rgb_t               wr_color;
  npcs_pkg::rgb_t               entry;
  npcs_pkg::tag_t               tag_dist;
  logic [npcs_pkg::DIST_W-1:0]  entry_dist;
  logic                         take_new;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ram_we   = accept && (in_op == npcs_pkg::OP_WRITE)
                 && ({1'b0, in_entry_index} < 9'(PALETTE_ENTRIES));
  assign ram_re   = (state_r == ST_SCAN);
  assign wr_color = '{red: in_red, green: in_green, blue: in_blue};

  npcs_ram #(
    .WIDTH (npcs_pkg::RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_entry_index[AW-1:0]),
    .wdata (wr_color),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (entry)
  );

  npcs_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (tag_rd_r),
    .query    (query_r),
    .entry    (entry),
    .tag_out  (tag_dist),
    .dist_out (entry_dist)
  );

  // Strict less keeps the lowest index on a tie
  assign take_new = tag_dist.valid && (tag_dist.first || (entry_dist < best_dist_r));

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    query_nxt     = query_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_dist_nxt  = out_dist_r;

    tag_rd_nxt.valid = ram_re;
    tag_rd_nxt.first = (addr_r == '0);
    tag_rd_nxt.last  = (addr_r == LAST_ADDR);
    tag_rd_nxt.idx   = npcs_pkg::IDX_W'(addr_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (take_new) begin
      best_idx_nxt  = tag_dist.idx;
      best_dist_nxt = entry_dist;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept && in_op == npcs_pkg::OP_QUERY) begin
          query_nxt = wr_color;
          addr_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (tag_dist.valid && tag_dist.last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = best_idx_r;
          out_dist_nxt  = best_dist_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      tag_rd_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
      tag_rd_r    <= tag_rd_nxt;
    end
    query_r     <= query_nxt;
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    out_idx_r   <= out_idx_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_best_index    = out_idx_r;
  assign out_best_distance = out_dist_r;
  assign out_exact_match   = (out_dist_r == '0);

endmodule

// ===== hw/rtl/npcs_ram.sv =====
module npcs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/npcs_dist.sv =====
module npcs_dist (
  input  logic                            clk,
  input  logic                            rst_n,
  input  npcs_pkg::tag_t                  tag_in,
  input  npcs_pkg::rgb_t                  query,
  input  npcs_pkg::rgb_t                  entry,
  output npcs_pkg::tag_t                  tag_out,
  output logic [npcs_pkg::DIST_W-1:0]     dist_out
);

  logic [npcs_pkg::CHAN_W-1:0] diff_r_c, diff_g_c, diff_b_c;
  logic [npcs_pkg::SQ_W-1:0]   sq_red_r, sq_green_r, sq_blue_r;
  logic [npcs_pkg::DIST_W-1:0] dist_r;
  npcs_pkg::tag_t              tag_sq_r, tag_sum_r;

  always_comb begin
    diff_r_c = (query.red >= entry.red) ? query.red - entry.red : entry.red - query.red;
    diff_g_c = (query.green >= entry.green) ? query.green - entry.green
                                            : entry.green - query.green;
    diff_b_c = (query.blue >= entry.blue) ? query.blue - entry.blue
                                          : entry.blue - query.blue;
  end

  // Stage one squares the channel differences, stage two sums them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_sq_r  <= '0;
      tag_sum_r <= '0;
    end else begin
      tag_sq_r  <= tag_in;
      tag_sum_r <= tag_sq_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_red_r   <= diff_r_c * diff_r_c;
    sq_green_r <= diff_g_c * diff_g_c;
    sq_blue_r  <= diff_b_c * diff_b_c;
    dist_r     <= npcs_pkg::DIST_W'(sq_red_r) + npcs_pkg::DIST_W'(sq_green_r)
                + npcs_pkg::DIST_W'(sq_blue_r);
  end

  assign tag_out  = tag_sum_r;
  assign dist_out = dist_r;

endmodule

// ===== hw/rtl/npcs_checker.sv =====
module npcs_checker #(
  parameter int PALETTE_ENTRIES = 256
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_op,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [npcs_pkg::IDX_W-1:0]      out_best_index,
  input logic [npcs_pkg::DIST_W-1:0]     out_best_distance,
  input logic                            out_exact_match
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_index)
      && $stable(out_best_distance) && $stable(out_exact_match))
    else $error("result beat changed while stalled");

  a_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exact_match == (out_best_distance == '0)))
    else $error("exact match disagrees with distance");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_best_index} < 9'(PALETTE_ENTRIES)))
    else $error("best index beyond palette");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == npcs_pkg::OP_QUERY |=> !in_ready)
    else $error("input ready right after a query beat");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == npcs_pkg::OP_WRITE |=> !$rose(out_valid))
    else $error("result appeared after a write beat");

endmodule

bind nearest_palette_color_search npcs_checker #(
  .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_npcs_checker (.*);
